>>> rtl/core/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes for the trajectory point queue: beat payloads,
// per-trajectory metadata word, operation and status codes, FSM states.
// ----------------------------------------------------------------------------
package tpq_pkg;

   // operation codes carried in the request mode field
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // response status codes
   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_DROPPED = 3'd1;
   localparam logic [2:0] ST_SENT    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_NO_SLOT = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] point_position;
      logic [31:0]        point_time;
      logic [7:0]         traj_id;
      logic [3:0]         traj_type;
      logic               relative_flag;
      logic [4:0]         point_count;
      logic               last_point;
      logic [1:0]         receiver_slots;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         sent_index;
      logic [4:0]         sent_count;
      logic [7:0]         sent_id;
      logic [3:0]         sent_type;
      logic signed [31:0] sent_position;
      logic [31:0]        sent_time;
      logic               sent_relative;
      logic               traj_done;
   } rsp_type;

   // metadata word kept per queue slot
   typedef struct packed {
      logic [7:0] traj_id;
      logic [3:0] traj_type;
      logic [4:0] point_count;
      logic       relative_flag;
   } meta_type;

   localparam int META_W  = $bits(meta_type);
   localparam int POINT_W = 64;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

>>> rtl/core/trajectory_point_queue_unit.sv
// ----------------------------------------------------------------------------
// trajectory_point_queue_unit
// Ring queue of motion trajectories loaded one point per beat and sent one
// point per transmit tick; drops whole trajectories when full.
// ----------------------------------------------------------------------------
// Flow: a request beat is taken in IDLE into req_ff and run in EXEC; its
// response is registered into rsp_ff when EXEC retires, which waits while
// the rsp output is stalled.
// A new request is taken only after the current one retires; the point and
// metadata RAM reads (registered read) sit between accept and state update.
// Reset: synchronous, active high; clears queue pointers, counts, point
// indices, drop flag and response valid. RAM contents are not cleared.
// Unused mode 3 is consumed without a response beat.
// ----------------------------------------------------------------------------
module trajectory_point_queue_unit
   import tpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_POINTS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int USED_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LIDX_W = $clog2(MAX_POINTS + 1);
   localparam int PDEPTH = QUEUE_DEPTH * MAX_POINTS;
   localparam int PA_W   = $clog2(PDEPTH);
   localparam int CMP_W  = IDX_W + 6;

   // ---- control state ----
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] head_slot_ff, head_slot_in;
   logic [SLOT_W-1:0] tail_slot_ff, tail_slot_in;   // head + used, wrapped
   logic [USED_W-1:0] used_slots_ff, used_slots_in;
   logic [IDX_W-1:0]  send_index_ff, send_index_in;
   logic [LIDX_W-1:0] load_index_ff, load_index_in;
   logic              dropping_ff, dropping_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // ---- payload registers ----
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;

   // ---- RAM ports ----
   logic              pt_wr_en;
   logic [PA_W-1:0]   pt_wr_addr, pt_rd_addr;
   logic [POINT_W-1:0] pt_wr_data, pt_rd_data;
   logic              meta_wr_en;
   meta_type          meta_wr_data, meta_rd_data;
   logic [META_W-1:0] meta_rd_bits;

   logic              out_free;
   logic              drop_now;
   logic [CMP_W-1:0]  next_send;
   logic [4:0]        sat_count;

   // Point store: {position, time} per (slot, index).
   tpq_ram #(
      .WIDTH (POINT_W),
      .DEPTH (PDEPTH)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   // Per-slot trajectory metadata.
   tpq_ram #(
      .WIDTH (META_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (tail_slot_ff),
      .wr_data (meta_wr_data),
      .rd_addr (head_slot_ff),
      .rd_data (meta_rd_bits)
   );

   assign meta_rd_data = meta_type'(meta_rd_bits);

   // Reads always target the head's next point. Pointers only move when an
   // item retires, so the read data is settled by the EXEC cycle and holds
   // while the response side stalls.
   assign pt_rd_addr = PA_W'(head_slot_ff) * PA_W'(MAX_POINTS) + PA_W'(send_index_ff);
   assign pt_wr_addr = PA_W'(tail_slot_ff) * PA_W'(MAX_POINTS) + PA_W'(load_index_ff);
   assign pt_wr_data = {req_ff.point_position, req_ff.point_time};

   assign sat_count = (32'(req_ff.point_count) > MAX_POINTS) ?
                      5'(MAX_POINTS) : req_ff.point_count;
   assign meta_wr_data = '{traj_id:       req_ff.traj_id,
                           traj_type:     req_ff.traj_type,
                           point_count:   sat_count,
                           relative_flag: req_ff.relative_flag};

   // A new trajectory meets a full queue: discard it through its last point.
   assign drop_now = dropping_ff ||
                     (load_index_ff == '0 && 32'(used_slots_ff) >= QUEUE_DEPTH);

   assign next_send = CMP_W'(send_index_ff) + CMP_W'(1);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_slot_ff  <= '0;
         tail_slot_ff  <= '0;
         used_slots_ff <= '0;
         send_index_ff <= '0;
         load_index_ff <= '0;
         dropping_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_slot_ff  <= head_slot_in;
         tail_slot_ff  <= tail_slot_in;
         used_slots_ff <= used_slots_in;
         send_index_ff <= send_index_in;
         load_index_ff <= load_index_in;
         dropping_ff   <= dropping_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_slot_in  = head_slot_ff;
      tail_slot_in  = tail_slot_ff;
      used_slots_in = used_slots_ff;
      send_index_in = send_index_ff;
      load_index_in = load_index_ff;
      dropping_in   = dropping_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      pt_wr_en      = 1'b0;
      meta_wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // retire only once the output register can take the beat
            if (out_free) begin
               state_in = S_IDLE;
               rsp_in   = '0;
               unique case (req_ff.mode)
                  MODE_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (drop_now) begin
                        rsp_in.status = ST_DROPPED;
                        dropping_in   = !req_ff.last_point;
                        if (req_ff.last_point) begin
                           load_index_in = '0;
                        end
                     end else begin
                        rsp_in.status = ST_STORED;
                        meta_wr_en    = 1'b1;
                        // points past the limit are accepted but not kept
                        if (32'(load_index_ff) < MAX_POINTS) begin
                           pt_wr_en      = 1'b1;
                           load_index_in = load_index_ff + LIDX_W'(1);
                        end
                        if (req_ff.last_point) begin
                           load_index_in = '0;
                           used_slots_in = used_slots_ff + USED_W'(1);
                           tail_slot_in  = (32'(tail_slot_ff) == QUEUE_DEPTH - 1) ?
                                           '0 : tail_slot_ff + SLOT_W'(1);
                        end
                     end
                  end
                  MODE_TICK: begin
                     rsp_valid_in = 1'b1;
                     if (used_slots_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (req_ff.receiver_slots == 2'd0) begin
                        rsp_in.status = ST_NO_SLOT;
                     end else begin
                        rsp_in.status        = ST_SENT;
                        rsp_in.sent_index    = 4'(send_index_ff);
                        rsp_in.sent_count    = meta_rd_data.point_count;
                        rsp_in.sent_id       = meta_rd_data.traj_id;
                        rsp_in.sent_type     = meta_rd_data.traj_type;
                        rsp_in.sent_relative = meta_rd_data.relative_flag;
                        rsp_in.sent_position = $signed(pt_rd_data[POINT_W-1:32]);
                        rsp_in.sent_time     = pt_rd_data[31:0];
                        // zero-count trajectories also finish after point 0
                        if (next_send >= CMP_W'(meta_rd_data.point_count)) begin
                           rsp_in.traj_done = 1'b1;
                           send_index_in    = '0;
                           used_slots_in    = used_slots_ff - USED_W'(1);
                           head_slot_in     = (32'(head_slot_ff) == QUEUE_DEPTH - 1) ?
                                              '0 : head_slot_ff + SLOT_W'(1);
                        end else begin
                           send_index_in = next_send[IDX_W-1:0];
                        end
                     end
                  end
                  MODE_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_CLEARED;
                     head_slot_in  = '0;
                     tail_slot_in  = '0;
                     used_slots_in = '0;
                     send_index_in = '0;
                     load_index_in = '0;
                     dropping_in   = 1'b0;
                  end
                  default: begin
                     // reserved mode: consumed silently
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---- assertions ----
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_slots_ff) <= QUEUE_DEPTH)
      else $error("queue occupancy exceeds depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      used_slots_ff == '0 |-> head_slot_ff == tail_slot_ff)
      else $error("empty queue with head and tail apart");

   a_send_bound: assert property (@(posedge clock) disable iff (reset)
      32'(send_index_ff) < MAX_POINTS && 32'(load_index_ff) <= MAX_POINTS)
      else $error("point index out of range");

   a_done_sent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.traj_done |-> rsp_ff.status == ST_SENT)
      else $error("trajectory done flagged without a sent point");

   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> load_index_ff == '0)
      else $error("drop in progress with a partial load");

endmodule

>>> rtl/core/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/trajectory_point_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trajectory_point_queue_unit_tb
// Self-checking bench for the trajectory point queue. A short directed table
// walks the empty queue, the no-slot case, field extremes, a zero-point
// trajectory, count saturation, a full queue with a dropped trajectory, and
// clears. A random part follows: mostly well-formed trajectories and transmit
// ticks, plus clears, unused-mode beats and truncated loads. Every response
// beat is checked against the in-bench queue model or a typed row's status.
// ----------------------------------------------------------------------------
module trajectory_point_queue_unit_tb;
   import tpq_pkg::*;

   localparam int QDEPTH = 8;
   localparam int MAXP   = 16;
   localparam logic [1:0] MODE_NOP = 2'd3;   // unused mode, consumed silently
   localparam int RAND_BEATS = 800;
   localparam int CALM_AFTER = 720;          // no idling past this point
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   trajectory_point_queue_unit #(
      .QUEUE_DEPTH(QDEPTH),
      .MAX_POINTS (MAXP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Queue model: point stores, per-slot metadata, ring pointers
   // ------------------------------------------------------------------------
   logic [31:0] pos_mem   [QDEPTH*MAXP];
   logic [31:0] time_mem  [QDEPTH*MAXP];
   bit          pt_written[QDEPTH*MAXP];   // store entries loaded at least once
   logic [7:0]  slot_id   [QDEPTH];
   logic [3:0]  slot_type [QDEPTH];
   logic [4:0]  slot_count[QDEPTH];
   logic        slot_rel  [QDEPTH];
   int unsigned head_slot, used_slots, send_idx, load_idx;
   bit          dropping;

   rsp_type     due_rsp_q[$];               // responses still owed by the DUT
   int          errors;
   bit          calm;
   int          ready_stall;

   // Advance the model by one request beat; returns 1 when a response is due.
   function automatic bit queue_step(input req_type r, output rsp_type o);
      int unsigned slot, cnt, idx, h;
      o = '0;
      case (r.mode)
         MODE_LOAD: begin
            // a new trajectory that finds the queue full is dropped whole
            if (!dropping && load_idx == 0 && used_slots >= QDEPTH) dropping = 1'b1;
            if (dropping) begin
               if (r.last_point) begin
                  dropping = 1'b0;
                  load_idx = 0;
               end
               o.status = ST_DROPPED;
               return 1'b1;
            end
            slot = (head_slot + used_slots) % QDEPTH;
            if (load_idx < MAXP) begin
               pos_mem[slot*MAXP + load_idx]    = r.point_position;
               time_mem[slot*MAXP + load_idx]   = r.point_time;
               pt_written[slot*MAXP + load_idx] = 1'b1;
               load_idx++;
            end
            cnt = (r.point_count > MAXP) ? MAXP : r.point_count;
            slot_id[slot]    = r.traj_id;
            slot_type[slot]  = r.traj_type;
            slot_rel[slot]   = r.relative_flag;
            slot_count[slot] = cnt[4:0];
            if (r.last_point) begin
               used_slots++;
               load_idx = 0;
            end
            o.status = ST_STORED;
            return 1'b1;
         end
         MODE_TICK: begin
            h = head_slot;
            if (used_slots == 0) begin
               o.status = ST_EMPTY;
               return 1'b1;
            end
            if (r.receiver_slots == 2'd0) begin
               o.status = ST_NO_SLOT;
               return 1'b1;
            end
            idx = (send_idx >= MAXP) ? MAXP - 1 : send_idx;
            o.status        = ST_SENT;
            o.sent_index    = idx[3:0];
            o.sent_count    = slot_count[h];
            o.sent_id       = slot_id[h];
            o.sent_type     = slot_type[h];
            o.sent_position = pos_mem[h*MAXP + idx];
            o.sent_time     = time_mem[h*MAXP + idx];
            o.sent_relative = slot_rel[h];
            send_idx = idx + 1;
            // zero-count trajectories still send point 0, then retire
            if (send_idx >= slot_count[h]) begin
               head_slot = (h + 1) % QDEPTH;
               used_slots--;
               send_idx = 0;
               o.traj_done = 1'b1;
            end
            return 1'b1;
         end
         MODE_CLEAR: begin
            head_slot  = 0;
            used_slots = 0;
            send_idx   = 0;
            load_idx   = 0;
            dropping   = 1'b0;
            o.status   = ST_CLEARED;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // A tick that would send a point never loaded into the store is illegal.
   function automatic bit head_point_unloaded(input logic [1:0] rs);
      int unsigned idx;
      idx = (send_idx >= MAXP) ? MAXP - 1 : send_idx;
      return used_slots != 0 && rs != 2'd0 && !pt_written[head_slot*MAXP + idx];
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: drives at falling edge, handshake seen at rising edge
   // ------------------------------------------------------------------------
   task automatic send_req(input req_type r);
      rsp_type due;
      if (queue_step(r, due)) due_rsp_q.push_back(due);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      // occasional idle gap before the next beat
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   function automatic req_type load_pt(input logic [31:0] pos, input logic [31:0] tm,
                                       input logic [7:0] id, input logic [3:0] ty,
                                       input logic rel, input logic [4:0] cnt,
                                       input logic last);
      req_type r;
      r = '0;
      r.mode           = MODE_LOAD;
      r.point_position = pos;
      r.point_time     = tm;
      r.traj_id        = id;
      r.traj_type      = ty;
      r.relative_flag  = rel;
      r.point_count    = cnt;
      r.last_point     = last;
      return r;
   endfunction

   function automatic req_type op_req(input logic [1:0] mode, input logic [1:0] rs);
      req_type r;
      r = '0;
      r.mode           = mode;
      r.receiver_slots = rs;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Directed table. typed rows carry a status that is obvious by inspection
   // and all other fields zero; the rest are checked against the model.
   // ------------------------------------------------------------------------
   typedef struct {
      req_type    req;
      bit         typed;
      logic [2:0] status;
   } plan_row_type;

   plan_row_type plan[$];

   task automatic add_row(input req_type r, input bit typed, input logic [2:0] st);
      plan_row_type row;
      row.req    = r;
      row.typed  = typed;
      row.status = st;
      plan.push_back(row);
   endtask

   task automatic run_plan();
      rsp_type due;
      rsp_type typed_rsp;
      foreach (plan[i]) begin
         // model always steps so its state tracks the DUT
         if (queue_step(plan[i].req, due)) begin
            if (plan[i].typed) begin
               typed_rsp        = '0;
               typed_rsp.status = plan[i].status;
               due_rsp_q.push_back(typed_rsp);
            end else begin
               due_rsp_q.push_back(due);
            end
         end
         req_data  <= plan[i].req;
         req_valid <= 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Random part: well-formed trajectories interleaved with ticks; clears,
   // unused-mode beats, stray metadata and early commits as noise.
   // ------------------------------------------------------------------------
   task automatic run_random();
      req_type     r, traj;
      int          beats, pts_left, fill_pct, roll, n;
      beats    = 0;
      pts_left = 0;
      fill_pct = 50;
      traj     = '0;
      while (beats < RAND_BEATS) begin
         if (beats % 60 == 0) fill_pct = $urandom_range(15, 85);
         if (beats >= CALM_AFTER) calm = 1'b1;
         // noise in fields that the chosen mode ignores
         r.mode           = MODE_TICK;
         r.point_position = $urandom;
         r.point_time     = $urandom;
         r.traj_id        = $urandom;
         r.traj_type      = $urandom;
         r.relative_flag  = $urandom;
         r.point_count    = $urandom;
         r.last_point     = $urandom;
         r.receiver_slots = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            r.mode   = MODE_CLEAR;
            pts_left = 0;
         end else if (roll < 3) begin
            r.mode = MODE_NOP;
         end else if (pts_left > 0 ? roll < 75 : roll < fill_pct) begin
            if (pts_left == 0) begin
               // mostly short trajectories; some fill the store, a few overrun it
               roll = $urandom_range(0, 99);
               n = (roll < 85) ? $urandom_range(1, 5) :
                   (roll < 95) ? $urandom_range(6, 16) : $urandom_range(17, 20);
               traj.traj_id       = $urandom;
               traj.traj_type     = $urandom;
               traj.relative_flag = $urandom;
               roll = $urandom_range(0, 99);
               traj.point_count = (roll < 80) ? n[4:0] :
                                  (roll < 90) ? 5'($urandom_range(0, 31)) : 5'(n - 1);
               pts_left = n;
            end
            r.mode           = MODE_LOAD;
            r.point_position = rand_word();
            r.point_time     = rand_word();
            if ($urandom_range(0, 19) != 0) begin
               r.traj_id       = traj.traj_id;
               r.traj_type     = traj.traj_type;
               r.relative_flag = traj.relative_flag;
               r.point_count   = traj.point_count;
            end
            pts_left--;
            // an early commit now and then truncates the trajectory
            if ($urandom_range(0, 32) == 0) pts_left = 0;
            r.last_point = (pts_left == 0);
         end else if (head_point_unloaded(r.receiver_slots)) begin
            // short trajectory declared longer: flush instead of reading junk
            r.mode   = MODE_CLEAR;
            pts_left = 0;
         end
         if (r.mode != MODE_NOP) beats++;
         send_req(r);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, quiet near the end
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (ready_stall > 0) begin
         ready_stall--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         ready_stall = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic field_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
      errors++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
   endtask

   // compare each accepted response beat with the oldest one owed
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp_q.size() == 0) begin
            errors++;
            $error("response beat with none outstanding: status %0d", rsp_data.status);
         end else begin
            want = due_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               field_mismatch("status", want.status, rsp_data.status);
            if (rsp_data.sent_index !== want.sent_index)
               field_mismatch("sent_index", want.sent_index, rsp_data.sent_index);
            if (rsp_data.sent_count !== want.sent_count)
               field_mismatch("sent_count", want.sent_count, rsp_data.sent_count);
            if (rsp_data.sent_id !== want.sent_id)
               field_mismatch("sent_id", want.sent_id, rsp_data.sent_id);
            if (rsp_data.sent_type !== want.sent_type)
               field_mismatch("sent_type", want.sent_type, rsp_data.sent_type);
            if (rsp_data.sent_position !== want.sent_position)
               field_mismatch("sent_position", want.sent_position, rsp_data.sent_position);
            if (rsp_data.sent_time !== want.sent_time)
               field_mismatch("sent_time", want.sent_time, rsp_data.sent_time);
            if (rsp_data.sent_relative !== want.sent_relative)
               field_mismatch("sent_relative", want.sent_relative, rsp_data.sent_relative);
            if (rsp_data.traj_done !== want.traj_done)
               field_mismatch("traj_done", want.traj_done, rsp_data.traj_done);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      errors      = 0;
      calm        = 1'b0;
      ready_stall = 0;
      head_slot   = 0;
      used_slots  = 0;
      send_idx    = 0;
      load_idx    = 0;
      dropping    = 1'b0;
      foreach (pt_written[i]) pt_written[i] = 1'b0;

      // empty queue, with and without a receiver slot; unused mode
      add_row(op_req(MODE_TICK, 2'd2), 1, ST_EMPTY);
      add_row(op_req(MODE_TICK, 2'd0), 1, ST_EMPTY);
      add_row(op_req(MODE_NOP, 2'd1), 0, ST_STORED);
      // two-point trajectory at the field extremes
      add_row(load_pt(32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1, 5'd2, 1'b0),
              1, ST_STORED);
      add_row(load_pt(32'h8000_0000, 32'h0, 8'hFF, 4'hF, 1'b1, 5'd2, 1'b1), 1, ST_STORED);
      add_row(op_req(MODE_TICK, 2'd0), 1, ST_NO_SLOT);
      add_row(op_req(MODE_TICK, 2'd2), 0, ST_SENT);
      add_row(op_req(MODE_TICK, 2'd1), 0, ST_SENT);
      // zero-count trajectory still sends point 0
      add_row(load_pt(32'h0, 32'h0, 8'h00, 4'h0, 1'b0, 5'd0, 1'b1), 1, ST_STORED);
      add_row(op_req(MODE_TICK, 2'd1), 0, ST_SENT);
      // declared count above the maximum saturates; cleared mid-send
      add_row(load_pt(32'hFFFF_FFFF, 32'h1234_5678, 8'h5A, 4'hA, 1'b1, 5'd31, 1'b1),
              1, ST_STORED);
      add_row(op_req(MODE_TICK, 2'd2), 0, ST_SENT);
      add_row(op_req(MODE_CLEAR, 2'd0), 1, ST_CLEARED);
      // fill every slot with one-point trajectories
      for (int k = 0; k < QDEPTH; k++)
         add_row(load_pt(32'h100 * k - 32'h300, 32'h10 * k, 8'(k + 1), 4'(k), 1'(k),
                         5'd1, 1'b1), 1, ST_STORED);
      // queue full: the next trajectory is dropped, first to last point
      add_row(load_pt(32'h1, 32'h2, 8'h77, 4'h7, 1'b0, 5'd2, 1'b0), 1, ST_DROPPED);
      add_row(load_pt(32'h3, 32'h4, 8'h77, 4'h7, 1'b0, 5'd2, 1'b1), 1, ST_DROPPED);
      add_row(op_req(MODE_TICK, 2'd1), 0, ST_SENT);
      add_row(op_req(MODE_CLEAR, 2'd0), 1, ST_CLEARED);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_plan();
      run_random();
      req_valid <= 1'b0;

      // drain outstanding responses, then allow for a late stray beat
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/core/tpq_pkg.sv
rtl/core/tpq_ram.sv
rtl/core/trajectory_point_queue_unit.sv
sim/trajectory_point_queue_unit_tb.sv
